/* rtl/core/pcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pcm_pkg;

    localparam int CORRIDOR_DEPTH = 64;
    localparam int VISITED_DEPTH  = 16;
    localparam int REF_WIDTH      = 32;

    // Fixed port field widths
    localparam int OP_W       = 2;
    localparam int OUT_REF_W  = 32;
    localparam int OUT_CNT_W  = 7;
    localparam int MAX_PATH_W = 7;
    localparam int MAX_PATH_RESET = 64;

    localparam int COR_IDX_W = $clog2(CORRIDOR_DEPTH);
    localparam int COR_CNT_W = $clog2(CORRIDOR_DEPTH + 1);
    localparam int VIS_IDX_W = $clog2(VISITED_DEPTH);
    localparam int VIS_CNT_W = $clog2(VISITED_DEPTH + 1);
    localparam int STEP_W    = (COR_CNT_W > VIS_CNT_W) ? COR_CNT_W : VIS_CNT_W;

    typedef logic [REF_WIDTH-1:0]  ref_t;
    typedef logic [COR_IDX_W-1:0]  cor_idx_t;
    typedef logic [COR_CNT_W-1:0]  cor_cnt_t;
    typedef logic [VIS_IDX_W-1:0]  vis_idx_t;
    typedef logic [VIS_CNT_W-1:0]  vis_cnt_t;
    typedef logic [STEP_W-1:0]     step_t;
    typedef logic [OUT_CNT_W-1:0]  out_cnt_t;
    typedef logic [OUT_REF_W-1:0]  out_ref_t;
    typedef logic [MAX_PATH_W-1:0] max_path_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR       = 2'd0,
        OP_APPEND_CORR = 2'd1,
        OP_APPEND_VIS  = 2'd2,
        OP_MERGE       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_CMP,
        CELL_ROT,
        CELL_SHIFT,
        CELL_CLR_HIT
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FIND,
        ST_CALC,
        ST_ALIGN,
        ST_INSERT,
        ST_EMIT
    } state_t;

    // Per-cell contents
    typedef struct packed {
        ref_t     poly;
        logic     hit;
        vis_idx_t hit_idx;
    } cell_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        cell_op_t mode;
        cor_idx_t addr;
        ref_t     data;
        vis_idx_t vidx;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/pcm_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface pcm_item_if;
    import pcm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [31:0]          poly_ref;

    modport source (output valid, output operation, output poly_ref, input ready);
    modport sink   (input valid, input operation, input poly_ref, output ready);
endinterface

interface pcm_result_if;
    import pcm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_REF_W-1:0] entry_ref;
    logic                 entry_valid;
    logic                 last;
    logic [OUT_CNT_W-1:0] new_count;
    logic                 matched;
    logic                 overflow;

    modport source (output valid, output entry_ref, output entry_valid, output last,
                    output new_count, output matched, output overflow, input ready);
    modport sink   (input valid, input entry_ref, input entry_valid, input last,
                    input new_count, input matched, input overflow, output ready);
endinterface

interface pcm_cfg_if;
    import pcm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MAX_PATH_W-1:0] max_path;

    modport source (output valid, output max_path, input ready);
    modport sink   (input valid, input max_path, output ready);
endinterface

`default_nettype wire

/* rtl/core/pcm_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcm_cell (
    input  wire                 clk,
    input  wire                 rst_n,
    input  pcm_pkg::cor_idx_t   idx,
    input  pcm_pkg::cell_ctl_t  ctl,
    input  pcm_pkg::cell_t      up,
    input  pcm_pkg::ref_t       down_ref,
    output pcm_pkg::cell_t      q
);
    import pcm_pkg::*;

    ref_t     poly_reg,    poly_next;
    logic     hit_reg,     hit_next;
    vis_idx_t hit_idx_reg, hit_idx_next;

    always_comb
    begin
        poly_next    = poly_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        case (ctl.mode)
            CELL_LOAD:
            begin
                if (idx == ctl.addr)
                begin
                    poly_next = ctl.data;
                end
            end
            CELL_CMP:
            begin
                // keep the earliest visited position that matches
                if (!hit_reg && (poly_reg == ctl.data))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = ctl.vidx;
                end
            end
            CELL_ROT:
            begin
                poly_next    = up.poly;
                hit_next     = up.hit;
                hit_idx_next = up.hit_idx;
            end
            CELL_SHIFT:
            begin
                poly_next = down_ref;
                hit_next  = 1'b0;
            end
            CELL_CLR_HIT:
            begin
                hit_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        poly_reg    <= poly_next;
        hit_idx_reg <= hit_idx_next;
    end

    assign q = '{poly: poly_reg, hit: hit_reg, hit_idx: hit_idx_reg};

endmodule

`default_nettype wire

/* rtl/core/pcm_chain.sv */
`timescale 1ns / 1ps
`default_nettype none

module pcm_chain (
    input  wire                 clk,
    input  wire                 rst_n,
    input  pcm_pkg::cell_ctl_t  ctl,
    output pcm_pkg::cell_t      head
);
    import pcm_pkg::*;

    cell_t cells [CORRIDOR_DEPTH];

    // Ring: rotate moves cell k+1 into cell k; shift moves cell k-1 into cell k
    for (genvar k = 0; k < CORRIDOR_DEPTH; k++)
    begin : g_cell
        ref_t down_ref;
        if (k == 0)
        begin : g_first
            assign down_ref = ctl.data;
        end
        else
        begin : g_rest
            assign down_ref = cells[k-1].poly;
        end

        pcm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (COR_IDX_W'(k)),
            .ctl      (ctl),
            .up       (cells[(k + 1) % CORRIDOR_DEPTH]),
            .down_ref (down_ref),
            .q        (cells[k])
        );
    end

    assign head = cells[0];

endmodule

`default_nettype wire

/* rtl/core/path_corridor_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// Clear and append requests: result registered on acceptance, one request
//   per cycle while the result side takes results.
// Merge: search the V visited entries, find by rotating all D = 64 chain cells, calc, align
//   to match position P, insert R visited entries, emit by rotating the D cells (one result
//   for an empty corridor, held by output stalls); without a match, align and insert are skipped.
// Reset (rst_n low, async): counts and overflow flag cleared, max_path = 64; stores kept.
module path_corridor_merge (
    input  wire            clk,
    input  wire            rst_n,
    pcm_item_if.sink       item,
    pcm_result_if.source   result,
    pcm_cfg_if.sink        cfg
);
    import pcm_pkg::*;

    state_t    state_reg,    state_next;
    cor_cnt_t  corr_cnt_reg, corr_cnt_next;
    vis_cnt_t  vis_cnt_reg,  vis_cnt_next;
    logic      ovf_reg,      ovf_next;
    max_path_t max_path_reg;
    step_t     step_reg,     step_next;
    logic      found_reg,    found_next;
    cor_idx_t  cp_reg,       cp_next;
    vis_idx_t  vp_reg,       vp_next;
    step_t     req_reg,      req_next;

    ref_t      vis_mem [VISITED_DEPTH];
    logic      vis_we;
    vis_idx_t  vis_waddr;
    vis_idx_t  vis_raddr;
    ref_t      vis_rd_reg;

    logic      out_valid_reg;
    out_ref_t  out_ref_reg;
    logic      out_ev_reg;
    logic      out_last_reg;
    out_cnt_t  out_cnt_reg;
    logic      out_matched_reg;
    logic      out_ovf_reg;

    logic      push;
    out_ref_t  p_ref;
    logic      p_ev;
    logic      p_last;
    out_cnt_t  p_cnt;
    logic      p_matched;
    logic      p_ovf;

    cell_ctl_t ctl;
    cell_t     head;

    logic      out_free;
    logic      item_acc;
    op_t       item_op;

    // merge length arithmetic
    step_t     lim_w;
    step_t     req_raw;
    step_t     req_c;
    step_t     tail_raw;
    logic [STEP_W:0] sum_w;
    step_t     tail_c;
    logic      emitting;

    pcm_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (head)
    );

    assign out_free   = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == ST_IDLE) && out_free;
    assign item_acc   = item.valid && item.ready;
    assign item_op    = op_t'(item.operation);
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        lim_w    = (max_path_reg > MAX_PATH_W'(CORRIDOR_DEPTH)) ? STEP_W'(CORRIDOR_DEPTH)
                                                               : STEP_W'(max_path_reg);
        req_raw  = STEP_W'(vis_cnt_reg) - STEP_W'(vp_reg);
        req_c    = (req_raw > lim_w) ? lim_w : req_raw;
        tail_raw = STEP_W'(corr_cnt_reg) - STEP_W'(cp_reg) - STEP_W'(1);
        sum_w    = {1'b0, req_c} + {1'b0, tail_raw};
        tail_c   = (sum_w > {1'b0, lim_w}) ? (lim_w - req_c) : tail_raw;
    end

    always_comb
    begin
        state_next    = state_reg;
        corr_cnt_next = corr_cnt_reg;
        vis_cnt_next  = vis_cnt_reg;
        ovf_next      = ovf_reg;
        step_next     = step_reg;
        found_next    = found_reg;
        cp_next       = cp_reg;
        vp_next       = vp_reg;
        req_next      = req_reg;
        vis_we        = 1'b0;
        vis_waddr     = vis_cnt_reg[VIS_IDX_W-1:0];
        ctl           = '{mode: CELL_HOLD, addr: '0, data: '0, vidx: '0};
        push          = 1'b0;
        p_ref         = '0;
        p_ev          = 1'b0;
        p_last        = 1'b1;
        p_cnt         = '0;
        p_matched     = 1'b0;
        p_ovf         = ovf_reg;
        emitting      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    case (item_op)
                        OP_CLEAR:
                        begin
                            corr_cnt_next = '0;
                            vis_cnt_next  = '0;
                            ovf_next      = 1'b0;
                        end
                        OP_APPEND_CORR:
                        begin
                            if (corr_cnt_reg < COR_CNT_W'(CORRIDOR_DEPTH))
                            begin
                                ctl.mode      = CELL_LOAD;
                                ctl.addr      = corr_cnt_reg[COR_IDX_W-1:0];
                                ctl.data      = ref_t'(item.poly_ref);
                                corr_cnt_next = corr_cnt_reg + COR_CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_APPEND_VIS:
                        begin
                            if (vis_cnt_reg < VIS_CNT_W'(VISITED_DEPTH))
                            begin
                                vis_we       = 1'b1;
                                vis_cnt_next = vis_cnt_reg + VIS_CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_MERGE:
                        begin
                            ctl.mode   = CELL_CLR_HIT;
                            found_next = 1'b0;
                            step_next  = '0;
                            state_next = ST_SEARCH;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (item_op != OP_MERGE)
                    begin
                        push  = 1'b1;
                        p_cnt = out_cnt_t'(corr_cnt_next);
                        p_ovf = ovf_next;
                    end
                end
            end
            ST_SEARCH:
            begin
                // one visited entry broadcast to all cells per cycle
                if (step_reg < STEP_W'(vis_cnt_reg))
                begin
                    ctl.mode  = CELL_CMP;
                    ctl.data  = vis_rd_reg;
                    ctl.vidx  = step_reg[VIS_IDX_W-1:0];
                    step_next = step_reg + STEP_W'(1);
                end
                else
                begin
                    step_next  = '0;
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                // full rotation; head holds original entry step_reg, last hit wins
                ctl.mode = CELL_ROT;
                if ((step_reg < STEP_W'(corr_cnt_reg)) && head.hit)
                begin
                    found_next = 1'b1;
                    cp_next    = step_reg[COR_IDX_W-1:0];
                    vp_next    = head.hit_idx;
                end
                if (step_reg == STEP_W'(CORRIDOR_DEPTH - 1))
                begin
                    step_next  = '0;
                    state_next = ST_CALC;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_CALC:
            begin
                step_next = '0;
                if (found_reg)
                begin
                    req_next      = req_c;
                    corr_cnt_next = COR_CNT_W'(req_c + tail_c);
                    state_next    = ST_ALIGN;
                end
                else
                begin
                    vis_cnt_next = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_ALIGN:
            begin
                // bring the entry after the match to cell 0
                ctl.mode = CELL_ROT;
                if (step_reg == STEP_W'(cp_reg))
                begin
                    step_next  = '0;
                    state_next = ST_INSERT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_INSERT:
            begin
                // oldest kept visited entry goes in first, newest ends in cell 0
                if (step_reg < req_reg)
                begin
                    ctl.mode  = CELL_SHIFT;
                    ctl.data  = vis_rd_reg;
                    step_next = step_reg + STEP_W'(1);
                end
                else
                begin
                    vis_cnt_next = '0;
                    step_next    = '0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (corr_cnt_reg == '0)
                begin
                    if (out_free)
                    begin
                        push       = 1'b1;
                        p_matched  = found_reg;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    emitting = step_reg < STEP_W'(corr_cnt_reg);
                    if (!emitting || out_free)
                    begin
                        ctl.mode = CELL_ROT;
                        if (emitting)
                        begin
                            push      = 1'b1;
                            p_ref     = out_ref_t'(head.poly);
                            p_ev      = 1'b1;
                            p_last    = step_reg == (STEP_W'(corr_cnt_reg) - STEP_W'(1));
                            p_cnt     = out_cnt_t'(corr_cnt_reg);
                            p_matched = found_reg;
                        end
                        if (step_reg == STEP_W'(CORRIDOR_DEPTH - 1))
                        begin
                            step_next  = '0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            step_next = step_reg + STEP_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // visited read address for the next cycle, data lands in vis_rd_reg
    always_comb
    begin
        if (state_next == ST_INSERT)
        begin
            vis_raddr = VIS_IDX_W'(STEP_W'(vis_cnt_reg) - req_next + step_next);
        end
        else
        begin
            vis_raddr = step_next[VIS_IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            corr_cnt_reg  <= '0;
            vis_cnt_reg   <= '0;
            ovf_reg       <= 1'b0;
            max_path_reg  <= MAX_PATH_W'(MAX_PATH_RESET);
            step_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            corr_cnt_reg <= corr_cnt_next;
            vis_cnt_reg  <= vis_cnt_next;
            ovf_reg      <= ovf_next;
            step_reg     <= step_next;
            found_reg    <= found_next;
            if (cfg.valid && cfg.ready)
            begin
                max_path_reg <= cfg.max_path;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg     <= cp_next;
        vp_reg     <= vp_next;
        req_reg    <= req_next;
        vis_rd_reg <= vis_mem[vis_raddr];
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= ref_t'(item.poly_ref);
        end
        if (push)
        begin
            out_ref_reg     <= p_ref;
            out_ev_reg      <= p_ev;
            out_last_reg    <= p_last;
            out_cnt_reg     <= p_cnt;
            out_matched_reg <= p_matched;
            out_ovf_reg     <= p_ovf;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.entry_ref   = out_ref_reg;
    assign result.entry_valid = out_ev_reg;
    assign result.last        = out_last_reg;
    assign result.new_count   = out_cnt_reg;
    assign result.matched     = out_matched_reg;
    assign result.overflow    = out_ovf_reg;

    a_corr_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        corr_cnt_reg <= COR_CNT_W'(CORRIDOR_DEPTH))
        else $error("corridor count beyond depth");

    a_vis_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vis_cnt_reg <= VIS_CNT_W'(VISITED_DEPTH))
        else $error("visited count beyond depth");

    a_merge_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && (item.operation == OP_MERGE)) |=> !item.ready)
        else $error("request accepted during merge");

    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.entry_valid) |-> (result.new_count != '0))
        else $error("corridor entry with zero length");

    a_emit_clears_vis: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (vis_cnt_reg == '0))
        else $error("visited list not cleared before emit");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import pcm_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS = 38;

    typedef struct {
        logic      is_cfg;
        op_t       op;
        ref_t      poly;
        max_path_t limit;
    } request_t;

    typedef struct packed {
        out_ref_t entry_ref;
        logic     entry_valid;
        logic     last;
        out_cnt_t new_count;
        logic     matched;
        logic     overflow;
    } corridor_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // tb-side copies of the block inputs, known from time zero
    logic      req_valid = 1'b0;
    op_t       req_op = OP_CLEAR;
    ref_t      req_ref = '0;
    logic      wr_valid = 1'b0;
    max_path_t wr_limit = '0;
    logic      out_ready = 1'b0;

    pcm_item_if   item_ch ();
    pcm_result_if result_ch ();
    pcm_cfg_if    cfg_ch ();

    assign item_ch.valid     = req_valid;
    assign item_ch.operation = req_op;
    assign item_ch.poly_ref  = req_ref;
    assign cfg_ch.valid      = wr_valid;
    assign cfg_ch.max_path   = wr_limit;
    assign result_ch.ready   = out_ready;

    path_corridor_merge u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    request_t      pending [$];
    corridor_out_t expected_entries [$];
    int            n_queued = 0;
    int            n_accepted = 0;
    int            n_err = 0;
    int            idle_cycles = 0;
    logic          quiet;

    // no idling on either side over a stretch of the run
    assign quiet = (n_accepted >= 120) && (n_accepted < 200);

    // predicted block state
    ref_t      cor_refs [CORRIDOR_DEPTH];
    int        cor_len = 0;
    ref_t      vis_refs [VISITED_DEPTH];
    int        vis_len = 0;
    logic      ovf_sticky = 1'b0;
    max_path_t path_limit = max_path_t'(MAX_PATH_RESET);

    ref_t ref_pool [6];

    function automatic void push_entry(ref_t poly, logic vld, logic lst, int cnt, logic hit);
        corridor_out_t e;
        e.entry_ref   = poly;
        e.entry_valid = vld;
        e.last        = lst;
        e.new_count   = out_cnt_t'(cnt);
        e.matched     = hit;
        e.overflow    = ovf_sticky;
        expected_entries = {expected_entries, e};
    endfunction

    function automatic void advance_corridor(op_t op, ref_t poly);
        int   cut_at;
        int   vis_at;
        int   keep_vis;
        int   keep_tail;
        int   lim;
        ref_t merged [CORRIDOR_DEPTH];
        logic hit;
        hit = 1'b0;
        cut_at = -1;
        vis_at = -1;
        case (op)
            OP_CLEAR:
            begin
                cor_len = 0;
                vis_len = 0;
                ovf_sticky = 1'b0;
            end
            OP_APPEND_CORR:
            begin
                if (cor_len < CORRIDOR_DEPTH)
                begin
                    cor_refs[cor_len] = poly;
                    cor_len++;
                end
                else
                    ovf_sticky = 1'b1;
            end
            OP_APPEND_VIS:
            begin
                if (vis_len < VISITED_DEPTH)
                begin
                    vis_refs[vis_len] = poly;
                    vis_len++;
                end
                else
                    ovf_sticky = 1'b1;
            end
            default:
            begin
                lim = (int'(path_limit) > CORRIDOR_DEPTH) ? CORRIDOR_DEPTH : int'(path_limit);
                // newest corridor entry wins; for it, the oldest visited match
                for (int i = cor_len - 1; i >= 0; i--)
                    for (int j = 0; j < vis_len; j++)
                        if (cut_at < 0 && cor_refs[i] == vis_refs[j])
                        begin
                            cut_at = i;
                            vis_at = j;
                        end
                if (cut_at >= 0)
                begin
                    hit = 1'b1;
                    keep_vis = vis_len - vis_at;
                    keep_tail = cor_len - cut_at - 1;
                    if (keep_vis > lim)
                        keep_vis = lim;
                    if (keep_vis + keep_tail > lim)
                        keep_tail = lim - keep_vis;
                    for (int k = 0; k < keep_vis; k++)
                        merged[k] = vis_refs[vis_len - 1 - k];
                    for (int k = 0; k < keep_tail; k++)
                        merged[keep_vis + k] = cor_refs[cut_at + 1 + k];
                    cor_len = keep_vis + keep_tail;
                    for (int k = 0; k < cor_len; k++)
                        cor_refs[k] = merged[k];
                end
                vis_len = 0;
            end
        endcase
        if (op != OP_MERGE || cor_len == 0)
            push_entry('0, 1'b0, 1'b1, cor_len, hit);
        else
            for (int k = 0; k < cor_len; k++)
                push_entry(cor_refs[k], 1'b1, k == cor_len - 1, cor_len, hit);
    endfunction

    function automatic void queue_req(op_t op, ref_t poly);
        request_t r;
        r.is_cfg = 1'b0;
        r.op     = op;
        r.poly   = poly;
        r.limit  = '0;
        pending = {pending, r};
        n_queued++;
    endfunction

    function automatic void queue_max_path(max_path_t value);
        request_t r;
        r.is_cfg = 1'b1;
        r.op     = OP_CLEAR;
        r.poly   = '0;
        r.limit  = value;
        pending = {pending, r};
    endfunction

    function automatic ref_t pick_ref();
        if ($urandom_range(0, 99) < 85)
            return ref_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // optional pool refresh, optional clear, corridor appends, visited appends, then a merge
    function automatic void queue_merge_run(int n_corr, int n_vis);
        if ($urandom_range(0, 1))
            for (int k = 0; k < 6; k++)
                case ($urandom_range(0, 9))
                    0: ref_pool[k] = '0;
                    1: ref_pool[k] = '1;
                    default: ref_pool[k] = $urandom;
                endcase
        if ($urandom_range(0, 1))
            queue_req(OP_CLEAR, $urandom);
        repeat (n_corr) queue_req(OP_APPEND_CORR, pick_ref());
        repeat (n_vis) queue_req(OP_APPEND_VIS, pick_ref());
        queue_req(OP_MERGE, $urandom);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            n_err++;
            if (n_err <= 40)
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // request driver: one request or one register write in flight at a time
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        logic item_busy;
        logic cfg_busy;
        logic next_req;
        logic next_wr;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            wr_valid  <= 1'b0;
        end
        else
        begin
            item_busy = req_valid;
            cfg_busy  = wr_valid;
            if (req_valid && item_ch.ready)
            begin
                advance_corridor(req_op, req_ref);
                void'(pending.pop_front());
                n_accepted++;
                item_busy = 1'b0;
            end
            if (wr_valid && cfg_ch.ready)
            begin
                path_limit = wr_limit;
                void'(pending.pop_front());
                cfg_busy = 1'b0;
            end
            next_req = item_busy;
            next_wr  = cfg_busy;
            if (!item_busy && !cfg_busy && pending.size() > 0)
            begin
                if (pending[0].is_cfg)
                begin
                    // register writes only once every result is back
                    if (expected_entries.size() == 0)
                    begin
                        next_wr = 1'b1;
                        wr_limit <= pending[0].limit;
                    end
                end
                else if (quiet || $urandom_range(0, 99) >= 8)
                begin
                    next_req = 1'b1;
                    req_op  <= pending[0].op;
                    req_ref <= pending[0].poly;
                end
            end
            req_valid <= next_req;
            wr_valid  <= next_wr;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        corridor_out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_entries.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 40)
                        $display("%0t: result expected none, got ref %h valid %b last %b",
                                 $time, result_ch.entry_ref, result_ch.entry_valid,
                                 result_ch.last);
                end
                else
                begin
                    want = expected_entries.pop_front();
                    check_field("entry_ref", want.entry_ref, result_ch.entry_ref);
                    check_field("entry_valid", want.entry_valid, result_ch.entry_valid);
                    check_field("last", want.last, result_ch.last);
                    check_field("new_count", want.new_count, result_ch.new_count);
                    check_field("matched", want.matched, result_ch.matched);
                    check_field("overflow", want.overflow, result_ch.overflow);
                end
            end
            out_ready <= quiet || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && item_ch.ready) || (wr_valid && cfg_ch.ready) ||
                (result_ch.valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        max_path_t phase_limits [6];
        int        phase_start;
        phase_limits = '{7'd5, 7'd1, 7'd127, 7'd64, 7'd0, 7'd1};
        phase_limits[5] = max_path_t'($urandom_range(1, 64));
        for (int k = 0; k < 6; k++)
            ref_pool[k] = $urandom;

        // directed: empty merge, no match, duplicate visited, last-entry match
        queue_req(OP_MERGE, 32'h0);
        queue_req(OP_APPEND_CORR, 32'h0000_0000);
        queue_req(OP_APPEND_CORR, 32'hFFFF_FFFF);
        queue_req(OP_APPEND_CORR, 32'h0000_0005);
        queue_req(OP_APPEND_VIS, 32'h1234_5678);
        queue_req(OP_MERGE, 32'hFFFF_FFFF);
        queue_req(OP_APPEND_VIS, 32'hFFFF_FFFF);
        queue_req(OP_APPEND_VIS, 32'hFFFF_FFFF);
        queue_req(OP_APPEND_VIS, 32'h0000_000C);
        queue_req(OP_MERGE, 32'h0);
        queue_req(OP_APPEND_VIS, 32'h0000_0005);
        queue_req(OP_MERGE, 32'h0);
        queue_req(OP_CLEAR, 32'hFFFF_FFFF);
        queue_req(OP_MERGE, 32'h0);
        // visited part longer than the limit
        queue_max_path(max_path_t'(2));
        queue_req(OP_APPEND_CORR, 32'hA5A5_0001);
        queue_req(OP_APPEND_CORR, 32'h5A5A_0002);
        queue_req(OP_APPEND_CORR, 32'hC3C3_0003);
        queue_req(OP_APPEND_VIS, 32'hA5A5_0001);
        queue_req(OP_APPEND_VIS, 32'h8000_0000);
        queue_req(OP_APPEND_VIS, 32'h7FFF_FFFF);
        queue_req(OP_APPEND_VIS, 32'h0F0F_0F0F);
        queue_req(OP_MERGE, 32'h0);

        for (int p = 0; p < 6; p++)
        begin
            queue_max_path(phase_limits[p]);
            phase_start = n_queued;
            // both lists past capacity once, with a full-length merge
            if (p == 2)
                queue_merge_run(CORRIDOR_DEPTH + 1, VISITED_DEPTH + 1);
            while (n_queued - phase_start < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 75)
                    queue_merge_run($urandom_range(0, 10), $urandom_range(0, 6));
                else
                    repeat ($urandom_range(1, 3))
                        queue_req(op_t'($urandom_range(0, 3)), $urandom);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending.size() != 0 || expected_entries.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
